// ----- design/bgf_pkg.sv -----
// ----------------------------------------------------------------------------
// bgf_pkg
// Shared types and constants of the background tile fetcher with pixel FIFO.
// ----------------------------------------------------------------------------
package bgf_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int LINE_WIDTH  = 160;
   localparam int TILE_PIXELS = 8;

   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

   // Configuration register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_LCD_CONTROL = 2'd0;
   localparam csr_index_type CSR_SCROLL_X    = 2'd1;
   localparam csr_index_type CSR_SCROLL_Y    = 2'd2;
   localparam csr_index_type CSR_BG_PALETTE  = 2'd3;

   localparam logic [7:0] LCDC_RESET   = 8'h91;
   localparam logic [7:0] PALETTE_RESET = 8'hFC;

   // LCDC bits
   localparam int LCDC_BG_ENABLE = 0;
   localparam int LCDC_MAP_AREA  = 3;
   localparam int LCDC_DATA_AREA = 4;

   // Video memory bases
   localparam logic [15:0] MAP_BASE_LOW    = 16'h9800;
   localparam logic [15:0] MAP_BASE_HIGH   = 16'h9C00;
   localparam logic [15:0] DATA_BASE_LOW   = 16'h8000;
   localparam logic [15:0] DATA_BASE_HIGH  = 16'h8800;
   localparam logic [15:0] IDLE_ADDR       = 16'h8000;
   localparam logic [7:0]  TILE_OFFSET     = 8'h80;

   typedef struct packed {
      logic       command;
      logic [7:0] line;
      logic       fetch_phase;
      logic [7:0] vram_data;
   } req_type;

   typedef struct packed {
      logic        pixel_valid;
      logic [7:0]  pixel_x;
      logic [1:0]  pixel_shade;
      logic        vram_read;
      logic [15:0] vram_addr;
   } rsp_type;

   typedef logic [TILE_PIXELS-1:0][1:0] shade_row_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } queue_ctl_type;

endpackage

// ----- design/bgf_queue.sv -----
// ----------------------------------------------------------------------------
// bgf_queue
// Shade FIFO: appends a row of eight shades at once, pops one per cycle while pop is set.
// ----------------------------------------------------------------------------
module bgf_queue
   import bgf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  queue_ctl_type       ctl,
   input  shade_row_type       push_row,
   output logic [QUEUE_CW-1:0] count,
   output logic [1:0]          head_shade
);

   localparam logic [QUEUE_AW:0] DEPTH_W = (QUEUE_AW + 1)'(QUEUE_DEPTH);

   logic [1:0]          store [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] head_ff, head_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic [QUEUE_AW-1:0] wr_index [TILE_PIXELS];

   always_comb begin
      logic [QUEUE_AW:0] sum;
      for (int i = 0; i < TILE_PIXELS; i++) begin
         sum = {1'b0, head_ff} + (QUEUE_AW + 1)'(count_ff) + (QUEUE_AW + 1)'(i);
         if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
         end
         wr_index[i] = sum[QUEUE_AW-1:0];
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         head_in  = '0;
         count_in = '0;
      end else begin
         if (ctl.push) begin
            count_in = count_in + QUEUE_CW'(TILE_PIXELS);
         end
         if (ctl.pop) begin
            count_in = count_in - QUEUE_CW'(1);
            head_in  = (head_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QUEUE_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Push only happens with at most eight held, so the row never overruns the store
   always_ff @(posedge clock) begin
      if (!ctl.clear && ctl.push) begin
         for (int i = 0; i < TILE_PIXELS; i++) begin
            store[wr_index[i]] <= push_row[i];
         end
      end
   end

   assign count      = count_ff;
   assign head_shade = store[head_ff];

endmodule

// ----- design/background_tile_fetcher_pixel_fifo.sv -----
// ----------------------------------------------------------------------------
// background_tile_fetcher_pixel_fifo
// Background tile fetcher with a 16-entry shade FIFO, one dot per word.
//
// Usage: each req word is one dot (or a line-start command). The rsp word
// it produces carries the pixel emitted on that dot, if any, and the video
// memory address whose byte the next req word must carry in vram_data.
// The fetcher steps on even dots through tile, data low, data high, idle
// and push; pixels leave the FIFO while it holds more than eight.
// The rsp word for a req word is registered and appears in the cycle after acceptance.
// Throughput: one word per cycle while req_stall is low; the dot logic sits between the state
// registers and a single output register.
// req_stall rises only while the output register holds a word and the
// receiver stalls it; the block then holds its state until the word is
// taken. Configuration writes (csr_) take effect at the next edge; the user
// must make them only while the block is idle, which the block does not enforce.
// Reset: synchronous; registers return to LCDC 0x91, scroll 0, palette
// 0xFC, fetcher at the tile step, FIFO empty, no output word pending.
// ----------------------------------------------------------------------------
module background_tile_fetcher_pixel_fifo
   import bgf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_write_en,
   input  csr_index_type csr_index,
   input  logic [7:0]    csr_write_data
);

   typedef enum logic [2:0] {
      ST_TILE,
      ST_LOW,
      ST_HIGH,
      ST_IDLE,
      ST_PUSH
   } fetch_state_type;

   fetch_state_type fetch_state_ff, fetch_state_in;
   logic [7:0]      lcdc_ff, scx_ff, scy_ff, palette_ff;
   logic [7:0]      column_ff, column_in;
   logic [7:0]      tile_ff, tile_in;
   logic [7:0]      plane_low_ff, plane_low_in;
   logic [7:0]      plane_high_ff, plane_high_in;
   logic [7:0]      dot_count_ff, dot_count_in;
   logic [7:0]      emitted_ff, emitted_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic                req_fire;
   queue_ctl_type       qctl;
   shade_row_type       push_row;
   logic [QUEUE_CW-1:0] q_count;
   logic [1:0]          q_head_shade;
   logic [QUEUE_CW-1:0] count_after_push;
   logic                push_ok;
   logic                push_keep;
   logic [7:0]          map_x, map_y;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;

   bgf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctl        (qctl),
      .push_row   (push_row),
      .count      (q_count),
      .head_shade (q_head_shade)
   );

   // Map two-bit colour indexes to shades, leftmost pixel first
   always_comb begin
      logic [1:0] idx;
      for (int i = 0; i < TILE_PIXELS; i++) begin
         idx         = {plane_high_ff[TILE_PIXELS-1-i], plane_low_ff[TILE_PIXELS-1-i]};
         push_row[i] = palette_ff[2*idx +: 2];
      end
   end

   assign push_ok   = (q_count <= QUEUE_CW'(TILE_PIXELS));
   // Push the row only when its column is at least eight minus the fine scroll (scx[2:0])
   assign push_keep = ({1'b0, column_ff} >= (9'(TILE_PIXELS) - {6'b0, scx_ff[2:0]}));

   always_comb begin
      fetch_state_in = fetch_state_ff;
      column_in      = column_ff;
      tile_in        = tile_ff;
      plane_low_in   = plane_low_ff;
      plane_high_in  = plane_high_ff;
      dot_count_in   = dot_count_ff;
      emitted_in     = emitted_ff;
      qctl           = '0;
      rsp_data_in    = '0;
      count_after_push = q_count;

      if (req_data.command) begin
         qctl.clear     = 1'b1;
         fetch_state_in = ST_TILE;
         column_in      = '0;
         dot_count_in   = '0;
         emitted_in     = '0;
      end else begin
         if (!req_data.fetch_phase) begin
            case (fetch_state_ff)
               ST_TILE: begin
                  if (lcdc_ff[LCDC_BG_ENABLE]) begin
                     tile_in = lcdc_ff[LCDC_DATA_AREA] ? req_data.vram_data
                                                      : req_data.vram_data + TILE_OFFSET;
                  end
                  column_in      = column_ff + 8'(TILE_PIXELS);
                  fetch_state_in = ST_LOW;
               end
               ST_LOW: begin
                  plane_low_in   = req_data.vram_data;
                  fetch_state_in = ST_HIGH;
               end
               ST_HIGH: begin
                  plane_high_in  = req_data.vram_data;
                  fetch_state_in = ST_IDLE;
               end
               ST_IDLE: begin
                  fetch_state_in = ST_PUSH;
               end
               ST_PUSH: begin
                  if (push_ok) begin
                     fetch_state_in = ST_TILE;
                     if (push_keep) begin
                        qctl.push        = 1'b1;
                        count_after_push = q_count + QUEUE_CW'(TILE_PIXELS);
                     end
                  end
               end
               default: begin
                  fetch_state_in = ST_TILE;
               end
            endcase
         end

         if (count_after_push > QUEUE_CW'(TILE_PIXELS)) begin
            qctl.pop = 1'b1;
            if (dot_count_ff >= {5'b0, scx_ff[2:0]}) begin
               if ({1'b0, emitted_ff} < 9'(LINE_WIDTH)) begin
                  rsp_data_in.pixel_valid = 1'b1;
                  rsp_data_in.pixel_x     = emitted_ff;
                  rsp_data_in.pixel_shade = q_head_shade;
               end
               if (emitted_ff != 8'hFF) begin
                  emitted_in = emitted_ff + 8'd1;
               end
            end
            if (dot_count_ff != 8'hFF) begin
               dot_count_in = dot_count_ff + 8'd1;
            end
         end
      end

      // Announce the byte the next fetch step consumes
      map_y = req_data.line + scy_ff;
      map_x = column_in + scx_ff;
      rsp_data_in.vram_addr = IDLE_ADDR;
      if (fetch_state_in == ST_TILE && lcdc_ff[LCDC_BG_ENABLE]) begin
         rsp_data_in.vram_read = 1'b1;
         rsp_data_in.vram_addr = (lcdc_ff[LCDC_MAP_AREA] ? MAP_BASE_HIGH : MAP_BASE_LOW)
                               | {6'b0, map_y[7:3], map_x[7:3]};
      end else if (fetch_state_in == ST_LOW || fetch_state_in == ST_HIGH) begin
         rsp_data_in.vram_read = 1'b1;
         rsp_data_in.vram_addr = (lcdc_ff[LCDC_DATA_AREA] ? DATA_BASE_LOW : DATA_BASE_HIGH)
                               + {4'b0, tile_in, map_y[2:0], fetch_state_in == ST_HIGH};
      end

      if (!req_fire) begin
         qctl = '0;
      end
   end

   assign rsp_valid_in = req_fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_state_ff <= ST_TILE;
         lcdc_ff        <= LCDC_RESET;
         scx_ff         <= '0;
         scy_ff         <= '0;
         palette_ff     <= PALETTE_RESET;
         column_ff      <= '0;
         tile_ff        <= '0;
         plane_low_ff   <= '0;
         plane_high_ff  <= '0;
         dot_count_ff   <= '0;
         emitted_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_LCD_CONTROL: lcdc_ff    <= csr_write_data;
               CSR_SCROLL_X:    scx_ff     <= csr_write_data;
               CSR_SCROLL_Y:    scy_ff     <= csr_write_data;
               CSR_BG_PALETTE:  palette_ff <= csr_write_data;
               default:         lcdc_ff    <= lcdc_ff;
            endcase
         end
         if (req_fire) begin
            fetch_state_ff <= fetch_state_in;
            column_ff      <= column_in;
            tile_ff        <= tile_in;
            plane_low_ff   <= plane_low_in;
            plane_high_ff  <= plane_high_in;
            dot_count_ff   <= dot_count_in;
            emitted_ff     <= emitted_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QUEUE_CW'(QUEUE_DEPTH))
      else $error("shade FIFO count above depth");

   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.command) |=> (q_count == '0 && fetch_state_ff == ST_TILE))
      else $error("line start did not clear FIFO and fetcher");

   a_pixel_in_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.pixel_valid) |-> ({1'b0, rsp_data_ff.pixel_x} < 9'(LINE_WIDTH)))
      else $error("pixel emitted beyond the line");

   a_idle_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.vram_read) |-> (rsp_data_ff.vram_addr == IDLE_ADDR))
      else $error("address announced without a read");

endmodule
